FILE: rtl/learning_bridge_forward_decision_core_macros.svh
// assertion macros for the learning bridge forward decision block
// both macros expect clk and rst_n in the scope where they are used
`ifndef LEARNING_BRIDGE_FORWARD_DECISION_CORE_MACROS_SVH
`define LEARNING_BRIDGE_FORWARD_DECISION_CORE_MACROS_SVH

// same-cycle implication
`define LBFD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbfd check failed");

// next-cycle implication
`define LBFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbfd check failed");

`endif

FILE: rtl/lbfd_pkg.sv
// shared types and constants for the learning bridge forward decision block
// no dependencies
package lbfd_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int NUM_PORTS   = 4;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  localparam int MAC_W       = 48;
  localparam int PORT_W      = 2;
  localparam int MASK_W      = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_W       = 48;
  localparam int GROUP_BIT   = 40;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PORT_EN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PORT0_MAC = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PORT1_MAC = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PORT2_MAC = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PORT3_MAC = 3'd4;

  // query held for the whole table scan
  typedef struct packed {
    logic [PORT_W-1:0] ingress_port;
    logic              is_send;
    logic [MAC_W-1:0]  dst_mac;
    logic [MAC_W-1:0]  src_mac;
  } query_t;

  // scan token handed from cell to cell
  typedef struct packed {
    logic              busy;
    logic              src_hit;
    logic              src_moved;
    logic [IDX_W-1:0]  src_idx;
    logic              free_hit;
    logic [IDX_W-1:0]  free_idx;
    logic              dst_hit;
    logic [PORT_W-1:0] dst_port;
  } scan_t;

  // table write broadcast to all cells
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [MAC_W-1:0]  mac;
    logic [PORT_W-1:0] port;
  } wr_t;

  typedef struct packed {
    logic [MASK_W-1:0] forward_mask;
    logic [MASK_W-1:0] indicate_mask;
    logic              learn_changed;
    logic              table_full;
  } result_t;

endpackage

FILE: rtl/lbfd_if.sv
// valid/ready channel interfaces for frame headers and decisions
// depends on lbfd_pkg
interface lbfd_in_if import lbfd_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [PORT_W-1:0] ingress_port;
  logic              is_send;
  logic [MAC_W-1:0]  dst_mac;
  logic [MAC_W-1:0]  src_mac;

  modport source (output valid, ingress_port, is_send, dst_mac, src_mac, input ready);
  modport sink   (input valid, ingress_port, is_send, dst_mac, src_mac, output ready);
endinterface

interface lbfd_out_if import lbfd_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] forward_mask;
  logic [MASK_W-1:0] indicate_mask;
  logic              learn_changed;
  logic              table_full;

  modport source (output valid, forward_mask, indicate_mask, learn_changed, table_full,
                  input ready);
  modport sink   (input valid, forward_mask, indicate_mask, learn_changed, table_full,
                  output ready);
endinterface

FILE: rtl/lbfd_cell.sv
// one table entry of the learning table plus its stage of the scan chain
// depends on lbfd_pkg
module lbfd_cell import lbfd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] my_idx,
  input  query_t           query,
  input  wr_t              wr,
  input  scan_t            scan_in,
  output scan_t            scan_out
);

  logic              valid_r;
  logic [MAC_W-1:0]  mac_r;
  logic [PORT_W-1:0] port_r;
  scan_t             scan_r;
  scan_t             scan_nxt;

  always_comb begin
    scan_nxt = scan_in;
    if (valid_r && mac_r == query.src_mac) begin
      scan_nxt.src_hit   = 1'b1;
      scan_nxt.src_moved = (port_r != query.ingress_port);
      scan_nxt.src_idx   = my_idx;
    end
    // lowest free entry wins
    if (!valid_r && !scan_in.free_hit) begin
      scan_nxt.free_hit = 1'b1;
      scan_nxt.free_idx = my_idx;
    end
    if (valid_r && mac_r == query.dst_mac) begin
      scan_nxt.dst_hit  = 1'b1;
      scan_nxt.dst_port = port_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      scan_r  <= '0;
    end else begin
      scan_r <= scan_nxt;
      if (wr.en && wr.idx == my_idx) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.idx == my_idx) begin
      mac_r  <= wr.mac;
      port_r <= wr.port;
    end
  end

  assign scan_out = scan_r;

endmodule

FILE: rtl/lbfd_decide.sv
// learning update and per-port forward/indicate decision from a finished scan
// depends on lbfd_pkg
module lbfd_decide import lbfd_pkg::*; (
  input  query_t                  query,
  input  scan_t                   scan,
  input  logic [MASK_W-1:0]       port_en,
  input  logic [3:0][MAC_W-1:0]   port_mac,
  output result_t                 res,
  output wr_t                     wr
);

  logic [MASK_W-1:0] en;
  logic              ing_ok;
  logic              dst_hit;
  logic [PORT_W-1:0] dst_port;
  logic [MAC_W-1:0]  ing_mac;
  logic              cand;
  logic              veto;

  always_comb begin
    en = '0;
    for (int a = 0; a < MASK_W; a++) begin
      if (a < NUM_PORTS) en[a] = port_en[a];
    end
    ing_ok  = en[query.ingress_port];
    ing_mac = port_mac[query.ingress_port];

    res      = '0;
    wr.en    = 1'b0;
    wr.idx   = scan.src_idx;
    wr.mac   = query.src_mac;
    wr.port  = query.ingress_port;
    dst_hit  = scan.dst_hit;
    dst_port = scan.dst_port;
    cand     = 1'b0;
    veto     = 1'b0;

    if (ing_ok) begin
      if (!query.is_send) begin
        if (scan.src_hit) begin
          wr.en             = scan.src_moved;
          res.learn_changed = scan.src_moved;
        end else if (scan.free_hit) begin
          wr.en             = 1'b1;
          wr.idx            = scan.free_idx;
          res.learn_changed = 1'b1;
        end else begin
          res.table_full = 1'b1;
        end
        // destination equal to the just learned source sees the new port
        if (query.dst_mac == query.src_mac && (scan.src_hit || scan.free_hit)) begin
          dst_hit  = 1'b1;
          dst_port = query.ingress_port;
        end
      end

      for (int a = 0; a < MASK_W; a++) begin
        if (en[a] && PORT_W'(a) != query.ingress_port) begin
          if (query.is_send) begin
            cand = (query.src_mac == ing_mac) || (query.src_mac == port_mac[a]);
          end else begin
            cand = (query.dst_mac != ing_mac);
          end
          veto = cand && dst_hit && dst_port != PORT_W'(a);
          res.forward_mask[a]  = cand && !veto;
          res.indicate_mask[a] = !veto &&
                                 (query.dst_mac[GROUP_BIT] || query.dst_mac == port_mac[a]);
        end
      end
    end
  end

endmodule

FILE: rtl/learning_bridge_forward_decision_core.sv
// learning bridge forward decision: a chain of TABLE_DEPTH table cells scans one
// frame header at a time, one cell per cycle; the result is registered for the
// output after the scan, and the next header is taken only once the result has
// moved to the output register (later while the previous result waits).
// synchronous active-low reset empties the table and clears the port registers.
module learning_bridge_forward_decision_core import lbfd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  lbfd_in_if.sink              in_ch,
  lbfd_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  state_t                state_r;
  logic                  launch_r;
  query_t                query_r;
  scan_t                 scan_r;
  logic [MASK_W-1:0]     port_en_r;
  logic [3:0][MAC_W-1:0] port_mac_r;
  logic                  out_valid_r;
  result_t               out_r;

  scan_t                 chain [TABLE_DEPTH+1];
  result_t               res;
  wr_t                   wr_dec;
  wr_t                   wr;
  logic                  in_xfer;
  logic                  out_free;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  always_comb begin
    chain[0]      = '0;
    chain[0].busy = launch_r;
  end

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    lbfd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .my_idx   (IDX_W'(k)),
      .query    (query_r),
      .wr       (wr),
      .scan_in  (chain[k]),
      .scan_out (chain[k+1])
    );
  end

  lbfd_decide u_decide (
    .query    (query_r),
    .scan     (scan_r),
    .port_en  (port_en_r),
    .port_mac (port_mac_r),
    .res      (res),
    .wr       (wr_dec)
  );

  // table is written only at the cycle the result is handed to the output register
  always_comb begin
    wr    = wr_dec;
    wr.en = wr_dec.en && (state_r == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_r       <= '0;
    end else begin
      launch_r <= in_xfer;
      case (state_r)
        S_IDLE: begin
          if (in_xfer) state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (chain[TABLE_DEPTH].busy) state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      // result register loads when it is empty or as the previous result leaves
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
        out_r       <= res;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      query_r.ingress_port <= in_ch.ingress_port;
      query_r.is_send      <= in_ch.is_send;
      query_r.dst_mac      <= in_ch.dst_mac;
      query_r.src_mac      <= in_ch.src_mac;
    end
    if (state_r == S_SCAN && chain[TABLE_DEPTH].busy) scan_r <= chain[TABLE_DEPTH];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_en_r  <= '0;
      port_mac_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_PORT_EN:   port_en_r     <= cfg_wdata[MASK_W-1:0];
        REG_PORT0_MAC: port_mac_r[0] <= cfg_wdata[MAC_W-1:0];
        REG_PORT1_MAC: port_mac_r[1] <= cfg_wdata[MAC_W-1:0];
        REG_PORT2_MAC: port_mac_r[2] <= cfg_wdata[MAC_W-1:0];
        REG_PORT3_MAC: port_mac_r[3] <= cfg_wdata[MAC_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.forward_mask  = out_r.forward_mask;
  assign out_ch.indicate_mask = out_r.indicate_mask;
  assign out_ch.learn_changed = out_r.learn_changed;
  assign out_ch.table_full    = out_r.table_full;

endmodule

FILE: rtl/lbfd_checker.sv
// port-level checks for the learning bridge forward decision block
// depends on lbfd_pkg and the macro header; bound to the top level below
`include "learning_bridge_forward_decision_core_macros.svh"

module lbfd_checker import lbfd_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [MASK_W-1:0] forward_mask,
  input logic [MASK_W-1:0] indicate_mask,
  input logic              learn_changed,
  input logic              table_full
);

  `LBFD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `LBFD_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(forward_mask) && $stable(indicate_mask))
  `LBFD_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
  `LBFD_ASSERT_NOW(a_learn_excl, out_valid, !(learn_changed && table_full))

endmodule

bind learning_bridge_forward_decision_core lbfd_checker u_lbfd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .forward_mask  (out_ch.forward_mask),
  .indicate_mask (out_ch.indicate_mask),
  .learn_changed (out_ch.learn_changed),
  .table_full    (out_ch.table_full)
);

FILE: sim/learning_bridge_forward_decision_core_tb.sv
// testbench for learning_bridge_forward_decision_core: random and directed frame headers,
// each decision checked against an in-bench model of the mac learning table
// depends on lbfd_pkg, the lbfd_in_if / lbfd_out_if interfaces and the core
`timescale 1ns / 100ps

module learning_bridge_forward_decision_core_tb;
  import lbfd_pkg::*;

  localparam int POOL_SIZE = 24;
  localparam logic [MAC_W-1:0] MAC_ZERO  = '0;
  localparam logic [MAC_W-1:0] MAC_BCAST = '1;
  localparam logic [MAC_W-1:0] HOST_A    = 48'h0200_0000_000A;
  localparam logic [MAC_W-1:0] HOST_B    = 48'h0200_0000_000B;
  localparam logic [MAC_W-1:0] MCAST_GRP = 48'h0100_5E00_0001;
  localparam logic [MAC_W-1:0] PMAC0     = 48'h0200_0000_1000;
  localparam logic [MAC_W-1:0] PMAC1     = 48'h0200_0000_1001;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_LONG_STALL} rx_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  lbfd_in_if  in_ch ();
  lbfd_out_if out_ch ();

  learning_bridge_forward_decision_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // model copy of the registers and the learning table
  logic [MASK_W-1:0] port_en_q;
  logic [MAC_W-1:0]  own_mac [NUM_PORTS];
  logic              tbl_valid [TABLE_DEPTH];
  logic [MAC_W-1:0]  tbl_mac [TABLE_DEPTH];
  logic [PORT_W-1:0] tbl_port [TABLE_DEPTH];
  int                tbl_used;

  result_t           pending_decisions [$];
  logic [MAC_W-1:0]  mac_pool [POOL_SIZE];
  logic [MAC_W-1:0]  fill_macs [$];
  int                errors;
  int                burst_left;

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[MAC_W-1:0];
  endfunction

  function automatic logic [MAC_W-1:0] pool_mac();
    return mac_pool[$urandom_range(0, POOL_SIZE-1)];
  endfunction

  // lowest valid entry holding mac, -1 on a miss
  function automatic int find_entry(logic [MAC_W-1:0] mac);
    int slot;
    slot = -1;
    for (int k = TABLE_DEPTH-1; k >= 0; k--)
      if (tbl_valid[k] && tbl_mac[k] == mac) slot = k;
    return slot;
  endfunction

  function automatic result_t predict_decision(query_t h);
    result_t           r;
    int                hit;
    int                free_slot;
    logic              cand;
    logic [MASK_W-1:0] en_ports;
    r = '0;
    en_ports = port_en_q & MASK_W'((1 << NUM_PORTS) - 1);
    if (!en_ports[h.ingress_port] || int'(h.ingress_port) >= NUM_PORTS) return r;
    // received frames learn their source before the lookup
    if (!h.is_send) begin
      hit = find_entry(h.src_mac);
      if (hit >= 0) begin
        if (tbl_port[hit] != h.ingress_port) begin
          tbl_port[hit] = h.ingress_port;
          r.learn_changed = 1'b1;
        end
      end else begin
        free_slot = -1;
        for (int k = TABLE_DEPTH-1; k >= 0; k--)
          if (!tbl_valid[k]) free_slot = k;
        if (free_slot >= 0) begin
          tbl_valid[free_slot] = 1'b1;
          tbl_mac[free_slot]   = h.src_mac;
          tbl_port[free_slot]  = h.ingress_port;
          tbl_used++;
          r.learn_changed = 1'b1;
        end else begin
          r.table_full = 1'b1;
        end
      end
    end
    hit = find_entry(h.dst_mac);
    for (int a = 0; a < NUM_PORTS; a++) begin
      if (en_ports[a] && a != int'(h.ingress_port)) begin
        if (h.is_send)
          cand = (h.src_mac == own_mac[h.ingress_port]) || (h.src_mac == own_mac[a]);
        else
          cand = (h.dst_mac != own_mac[h.ingress_port]);
        // destination known on another port vetoes both bits of a candidate port
        if (!(cand && hit >= 0 && int'(tbl_port[hit]) != a)) begin
          r.forward_mask[a]  = cand;
          r.indicate_mask[a] = h.dst_mac[GROUP_BIT] || (h.dst_mac == own_mac[a]);
        end
      end
    end
    return r;
  endfunction

  function automatic query_t make_header(logic [PORT_W-1:0] port, logic send,
                                         logic [MAC_W-1:0] dst, logic [MAC_W-1:0] src);
    query_t h;
    h.ingress_port = port;
    h.is_send      = send;
    h.dst_mac      = dst;
    h.src_mac      = src;
    return h;
  endfunction

  function automatic query_t rand_header(int fresh_pct);
    query_t h;
    int     pick;
    h.ingress_port = PORT_W'($urandom_range(0, NUM_PORTS-1));
    h.is_send      = ($urandom_range(0, 9) < 3);
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      h.dst_mac = own_mac[$urandom_range(0, NUM_PORTS-1)];
    end else if (pick < 35) begin
      h.dst_mac = pool_mac();
      h.dst_mac[GROUP_BIT] = 1'b1;
    end else if (pick < 42) begin
      h.dst_mac = MAC_BCAST;
    end else if (pick < 50) begin
      h.dst_mac = rand_mac();
    end else begin
      h.dst_mac = pool_mac();
    end
    pick = $urandom_range(0, 99);
    if (h.is_send) begin
      if (pick < 40)      h.src_mac = own_mac[h.ingress_port];
      else if (pick < 65) h.src_mac = own_mac[$urandom_range(0, NUM_PORTS-1)];
      else if (pick < 90) h.src_mac = pool_mac();
      else                h.src_mac = rand_mac();
    end else if (pick < fresh_pct) begin
      h.src_mac = rand_mac();
    end else begin
      h.src_mac = pool_mac();
    end
    return h;
  endfunction

  // drive one header in bursts with random gaps, record the decision at its transfer
  task automatic send_frame(input query_t h);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 4);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    @(negedge clk);
    in_ch.valid        <= 1'b1;
    in_ch.ingress_port <= h.ingress_port;
    in_ch.is_send      <= h.is_send;
    in_ch.dst_mac      <= h.dst_mac;
    in_ch.src_mac      <= h.src_mac;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_decisions.insert(pending_decisions.size(), predict_decision(h));
    burst_left--;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_PORT_EN:   port_en_q  = data[MASK_W-1:0];
      REG_PORT0_MAC: own_mac[0] = data[MAC_W-1:0];
      REG_PORT1_MAC: own_mac[1] = data[MAC_W-1:0];
      REG_PORT2_MAC: own_mac[2] = data[MAC_W-1:0];
      REG_PORT3_MAC: own_mac[3] = data[MAC_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [MASK_W-1:0] en, input logic [MAC_W-1:0] m0,
                               input logic [MAC_W-1:0] m1, input logic [MAC_W-1:0] m2,
                               input logic [MAC_W-1:0] m3);
    logic [CFG_W-1:0] en_word;
    // junk above the enable bits must be dropped
    en_word = rand_mac();
    en_word[MASK_W-1:0] = en;
    wait_idle();
    set_register(REG_PORT_EN, en_word);
    set_register(REG_PORT0_MAC, m0);
    set_register(REG_PORT1_MAC, m1);
    set_register(REG_PORT2_MAC, m2);
    set_register(REG_PORT3_MAC, m3);
  endtask

  // registers at reset: every port disabled, so every decision is empty
  task automatic test_after_reset();
    repeat (4) send_frame(rand_header(50));
  endtask

  task automatic test_directed_decisions();
    apply_setting(4'hF, PMAC0, PMAC1, MAC_ZERO, MAC_BCAST);
    send_frame(make_header(2'd0, 1'b0, MAC_BCAST, HOST_A));  // new source, broadcast
    send_frame(make_header(2'd1, 1'b0, MCAST_GRP, HOST_A));  // source moves port
    send_frame(make_header(2'd1, 1'b0, HOST_B, HOST_A));     // same port, unknown dst
    send_frame(make_header(2'd2, 1'b0, HOST_A, HOST_B));     // dst known elsewhere
    send_frame(make_header(2'd3, 1'b0, PMAC1, HOST_B));      // dst is a target's own mac
    send_frame(make_header(2'd0, 1'b0, PMAC0, HOST_A));      // dst is ingress own mac
    send_frame(make_header(2'd0, 1'b1, HOST_B, PMAC0));      // sent from ingress mac
    send_frame(make_header(2'd1, 1'b1, HOST_B, MAC_BCAST));  // sent from port 3 mac
    send_frame(make_header(2'd2, 1'b1, MCAST_GRP, HOST_A));  // sent from foreign mac
    send_frame(make_header(2'd2, 1'b1, MAC_ZERO, MAC_ZERO));
    send_frame(make_header(2'd3, 1'b0, MAC_BCAST, MAC_BCAST));
    send_frame(make_header(2'd0, 1'b0, MAC_BCAST, MAC_ZERO)); // broadcast now learned
    send_frame(make_header(2'd3, 1'b1, MAC_ZERO, MAC_BCAST));
    send_frame(make_header(2'd1, 1'b0, PMAC0, PMAC1));
    // disabled ingress ports give empty decisions and learn nothing
    wait_idle();
    set_register(REG_PORT_EN, {{(CFG_W-MASK_W){1'b0}}, 4'b0101});
    send_frame(make_header(2'd1, 1'b0, MAC_BCAST, HOST_A));
    send_frame(make_header(2'd3, 1'b0, HOST_A, 48'h0200_0000_00C3));
    send_frame(make_header(2'd2, 1'b0, MAC_BCAST, HOST_A));
    send_frame(make_header(2'd0, 1'b1, HOST_A, PMAC0));
    // writes beyond the register list change nothing
    wait_idle();
    for (int i = int'(REG_PORT3_MAC) + 1; i < 2**CFG_IDX_W; i++) begin
      set_register(CFG_IDX_W'(i), MAC_BCAST);
      set_register(CFG_IDX_W'(i), rand_mac());
    end
    send_frame(make_header(2'd2, 1'b0, PMAC1, HOST_B));
    send_frame(make_header(2'd0, 1'b0, MCAST_GRP, HOST_B));
  endtask

  task automatic test_random_traffic();
    int n;
    for (int phase = 0; phase < 7; phase++) begin
      n = 130;
      case (phase)
        0: apply_setting(4'hF, mac_pool[2], mac_pool[3], mac_pool[4], mac_pool[5]);
        1: apply_setting(4'hF, MAC_ZERO, MAC_BCAST, mac_pool[6], MAC_ZERO);
        2: apply_setting(MASK_W'($urandom_range(1, 15)), rand_mac(), rand_mac(),
                         rand_mac(), rand_mac());
        3: begin
          apply_setting(4'h0, pool_mac(), pool_mac(), pool_mac(), pool_mac());
          n = 10;
        end
        4: begin
          apply_setting(MASK_W'(1 << $urandom_range(0, NUM_PORTS-1)), pool_mac(),
                        pool_mac(), pool_mac(), pool_mac());
          n = 30;
        end
        5: apply_setting(MASK_W'($urandom_range(0, 15)), pool_mac(), pool_mac(),
                         pool_mac(), pool_mac());
        default: begin
          apply_setting(4'hF, MAC_BCAST, MAC_BCAST, MAC_BCAST, MAC_BCAST);
          n = 100;
        end
      endcase
      repeat (n) send_frame(rand_header(5));
    end
  endtask

  task automatic test_table_full();
    query_t h;
    apply_setting(4'hF, mac_pool[7], mac_pool[8], mac_pool[9], mac_pool[10]);
    while (tbl_used < TABLE_DEPTH) begin
      h = make_header(PORT_W'($urandom_range(0, NUM_PORTS-1)), 1'b0, pool_mac(), rand_mac());
      send_frame(h);
      fill_macs.insert(fill_macs.size(), h.src_mac);
    end
    // full table: known sources still move, new ones are dropped
    repeat (120) begin
      h = rand_header(25);
      if (!h.is_send && $urandom_range(0, 2) == 0)
        h.src_mac = fill_macs[$urandom_range(0, fill_macs.size()-1)];
      if ($urandom_range(0, 3) == 0)
        h.dst_mac = fill_macs[$urandom_range(0, fill_macs.size()-1)];
      send_frame(h);
    end
  endtask

  // receiver ready pattern, switching to a random mode after each random-length span
  initial begin : receiver_pattern
    rx_mode_t mode;
    int       span;
    int       tick;
    out_ch.ready = 1'b0;
    tick = 0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(20, 400);
      repeat (span) begin
        @(negedge clk);
        tick++;
        case (mode)
          RX_ALWAYS:   out_ch.ready <= 1'b1;
          RX_RANDOM:   out_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_PERIODIC: out_ch.ready <= ((tick % 7) >= 3);
          default:     out_ch.ready <= ((tick % 40) < 6);
        endcase
      end
    end
  end

  task automatic check_field(input string name, input logic [MASK_W-1:0] want,
                             input logic [MASK_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : decision_check
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_decisions.size() == 0) begin
        errors++;
        $display("%0t: unexpected decision, expected none actual fwd %h ind %h lrn %b full %b",
                 $time, out_ch.forward_mask, out_ch.indicate_mask, out_ch.learn_changed,
                 out_ch.table_full);
      end else begin
        want = pending_decisions.pop_front();
        check_field("forward_mask", want.forward_mask, out_ch.forward_mask);
        check_field("indicate_mask", want.indicate_mask, out_ch.indicate_mask);
        check_field("learn_changed", want.learn_changed, out_ch.learn_changed);
        check_field("table_full", want.table_full, out_ch.table_full);
      end
    end
  end

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = '0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.ingress_port = '0;
    in_ch.is_send      = 1'b0;
    in_ch.dst_mac      = '0;
    in_ch.src_mac      = '0;
    errors     = 0;
    burst_left = 0;
    port_en_q  = '0;
    tbl_used   = 0;
    for (int p = 0; p < NUM_PORTS; p++) own_mac[p] = '0;
    for (int k = 0; k < TABLE_DEPTH; k++) tbl_valid[k] = 1'b0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      mac_pool[i] = rand_mac();
      if (i % 2 == 0) mac_pool[i][GROUP_BIT] = 1'b0;
    end
    mac_pool[0] = MAC_ZERO;
    mac_pool[1] = MAC_BCAST;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_after_reset();
    test_directed_decisions();
    test_random_traffic();
    test_table_full();

    wait_idle();
    repeat (2 * TABLE_DEPTH) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
